// ----- sv/indexed_insert_delete_list_top_defines.svh -----
// assertion macros for the indexed insert/delete list
`ifndef INDEXED_INSERT_DELETE_LIST_TOP_DEFINES_SVH
`define INDEXED_INSERT_DELETE_LIST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IIDL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("iidl assertion failed");
`define IIDL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iidl implication failed");
`define IIDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iidl next-cycle check failed");
`else
`define IIDL_ASSERT(lbl, clk, rst_n, prop)
`define IIDL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IIDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/iidl_pkg.sv -----
// shared types and constants of the indexed insert/delete list
package iidl_pkg;

    localparam int MODE_W        = 2;
    localparam int POS_W         = 5;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 5;
    localparam int CAP_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CAP_W-1:0]         CAP_RESET = CAP_W'(16);
    localparam logic signed [DATA_W-1:0] FAIL_DATA = '1;
    localparam logic signed [DATA_W-1:0] ZERO_DATA = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic                     upd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } t_cell_ctrl;

endpackage

// ----- sv/iidl_if.sv -----
// request and response channel interfaces
interface iidl_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [iidl_pkg::MODE_W-1:0]              mode;
    logic [iidl_pkg::POS_W-1:0]               position;
    logic signed [iidl_pkg::DATA_W-1:0]       value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface iidl_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     status;
    logic signed [iidl_pkg::DATA_W-1:0]       data;
    logic [iidl_pkg::COUNT_W-1:0]             count;

    modport source (output valid, output status, output data, output count, input ready);
    modport sink   (input valid, input status, input data, input count, output ready);
endinterface

// ----- sv/iidl_cell.sv -----
// one list cell: holds an entry and shifts with its neighbors
module iidl_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = iidl_pkg::POS_W
) (
    input  logic                             i_clk,
    input  iidl_pkg::t_cell_ctrl             i_ctrl,
    input  logic signed [iidl_pkg::DATA_W-1:0] i_left,
    input  logic signed [iidl_pkg::DATA_W-1:0] i_right,
    output logic signed [iidl_pkg::DATA_W-1:0] o_val,
    output logic signed [iidl_pkg::DATA_W-1:0] o_rd
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic signed [iidl_pkg::DATA_W-1:0] r_val;
    logic signed [iidl_pkg::DATA_W-1:0] n_val;
    logic [CMP_W-1:0]                   w_pos;
    logic                               w_here;
    logic                               w_above;

    assign w_pos   = CMP_W'(i_ctrl.pos);
    assign w_here  = (IDX == w_pos);
    assign w_above = (IDX > w_pos);

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            if (w_here) begin
                n_val = i_ctrl.val;
            end else if (w_above) begin
                n_val = i_left;
            end
        end else if (i_ctrl.del) begin
            if (w_here || w_above) begin
                n_val = i_right;
            end
        end else if (i_ctrl.upd && w_here) begin
            n_val = i_ctrl.val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = w_here ? r_val : iidl_pkg::ZERO_DATA;

endmodule

// ----- sv/indexed_insert_delete_list_top.sv -----
// top level of the indexed insert/delete list
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells.
// Every cell compares its own index with the request position and shifts,
// loads or holds in the same cycle, for insert, delete, update and read
// alike. A request is taken every cycle unless stalled; its response is in
// the output register on the next cycle. The request side stalls only while
// that register holds a response that the sink has not taken. A failing
// request (bad position, full or empty list) returns status 1 and data -1
// and leaves the list as it was. Capacity register writes are taken out of
// reset on any edge with i_cfg_we high; a capacity over DEPTH acts as DEPTH.
`include "indexed_insert_delete_list_top_defines.svh"

module indexed_insert_delete_list_top #(
    parameter int DEPTH = iidl_pkg::DEPTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [iidl_pkg::CAP_W-1:0]   i_cfg_wdata,
    iidl_req_if.sink                     i_req,
    iidl_rsp_if.source                   o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > iidl_pkg::POS_W) ? CNT_W : iidl_pkg::POS_W;

    logic [iidl_pkg::CAP_W-1:0]          r_cap;
    logic [CNT_W-1:0]                    r_used;
    logic [CNT_W-1:0]                    n_used;
    logic                                r_rsp_valid;
    logic                                r_status;
    logic signed [iidl_pkg::DATA_W-1:0]  r_data;
    logic [iidl_pkg::COUNT_W-1:0]        r_count;

    logic                                w_acc;
    iidl_pkg::t_mode                     w_mode;
    logic [CMP_W-1:0]                    w_pos;
    logic [CMP_W-1:0]                    w_used;
    logic [CMP_W-1:0]                    w_cap;
    logic [CMP_W-1:0]                    w_cap_eff;
    logic                                w_ins_ok;
    logic                                w_oth_ok;
    logic                                w_fail;
    logic signed [iidl_pkg::DATA_W-1:0]  w_data;
    logic signed [iidl_pkg::DATA_W-1:0]  w_rd_data;
    logic [CNT_W-1:0]                    w_used_after;
    logic [CMP_W-1:0]                    w_count_ext;
    iidl_pkg::t_cell_ctrl                w_ctrl;

    logic signed [iidl_pkg::DATA_W-1:0]  w_val [DEPTH];
    logic signed [iidl_pkg::DATA_W-1:0]  w_rd  [DEPTH];

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_mode      = iidl_pkg::t_mode'(i_req.mode);

    assign w_pos     = CMP_W'(i_req.position);
    assign w_used    = CMP_W'(r_used);
    assign w_cap     = CMP_W'(r_cap);
    assign w_cap_eff = (w_cap > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : w_cap;
    assign w_ins_ok  = (w_pos <= w_used) && (w_used < w_cap_eff);
    assign w_oth_ok  = (w_pos < w_used);

    // read port: each cell drives its entry only when addressed
    always_comb begin
        w_rd_data = iidl_pkg::ZERO_DATA;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_data = w_rd_data | w_rd[k];
        end
    end

    always_comb begin
        w_fail       = 1'b0;
        w_data       = iidl_pkg::ZERO_DATA;
        w_used_after = r_used;
        w_ctrl.ins   = 1'b0;
        w_ctrl.del   = 1'b0;
        w_ctrl.upd   = 1'b0;
        w_ctrl.pos   = i_req.position;
        w_ctrl.val   = i_req.value;
        case (w_mode)
            iidl_pkg::MODE_INSERT: begin
                if (w_ins_ok) begin
                    w_ctrl.ins   = w_acc;
                    w_used_after = r_used + CNT_W'(1);
                end else begin
                    w_fail = 1'b1;
                end
            end
            iidl_pkg::MODE_DELETE: begin
                if (w_oth_ok) begin
                    w_ctrl.del   = w_acc;
                    w_data       = w_rd_data;
                    w_used_after = r_used - CNT_W'(1);
                end else begin
                    w_fail = 1'b1;
                end
            end
            iidl_pkg::MODE_UPDATE: begin
                if (w_oth_ok) begin
                    w_ctrl.upd = w_acc;
                end else begin
                    w_fail = 1'b1;
                end
            end
            iidl_pkg::MODE_READ: begin
                if (w_oth_ok) begin
                    w_data = w_rd_data;
                end else begin
                    w_fail = 1'b1;
                end
            end
            default: begin
                w_fail = 1'b1;
            end
        endcase
        if (w_fail) begin
            w_data = iidl_pkg::FAIL_DATA;
        end
    end

    assign n_used      = w_acc ? w_used_after : r_used;
    assign w_count_ext = CMP_W'(w_used_after);

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [iidl_pkg::DATA_W-1:0] w_left;
        logic signed [iidl_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = iidl_pkg::ZERO_DATA;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        iidl_cell #(
            .INDEX (g),
            .CMP_W (CMP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[g]),
            .o_rd    (w_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= iidl_pkg::CAP_RESET;
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_used <= n_used;
            if (w_acc) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= w_fail;
            r_data   <= w_data;
            r_count  <= w_count_ext[iidl_pkg::COUNT_W-1:0];
        end
    end

    assign o_rsp.valid  = r_rsp_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.data   = r_data;
    assign o_rsp.count  = r_count;

    `IIDL_ASSERT(a_used_le_depth, i_clk, i_rst_n, r_used <= CNT_W'(DEPTH))
    `IIDL_ASSERT_NEXT(a_fail_keeps_used, i_clk, i_rst_n, w_acc && w_fail, r_used == $past(r_used))
    `IIDL_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctrl.ins, r_used == $past(r_used) + CNT_W'(1))
    `IIDL_ASSERT_IMPL(a_held_rsp_stalls, i_clk, i_rst_n, r_rsp_valid && !o_rsp.ready, !i_req.ready)
    `IIDL_ASSERT_NEXT(a_rsp_count_match, i_clk, i_rst_n, w_acc, CMP_W'(o_rsp.count) == (CMP_W'(r_used) & CMP_W'(5'h1f)))

endmodule
